// File: hdl/ptlru_pkg.sv
// Shared types and constants for the page translation unit with LRU replacement.
`default_nettype none

package ptlru_pkg;

    localparam int VA_W       = 12;
    localparam int PHYS_W     = 10;
    localparam int FAULT_W    = 16;
    localparam int STAMP_W    = 32;
    localparam int IDX_MAX_W  = 6;
    localparam int PAGE_MAX_W = 10;

    localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hFFFF;

    typedef struct packed {
        logic                  valid;
        logic                  have;
        logic                  free;
        logic [IDX_MAX_W-1:0]  idx;
        logic [STAMP_W-1:0]    stamp;
        logic [PAGE_MAX_W-1:0] owner;
    } t_cand;

    typedef struct packed {
        logic                  en;
        logic                  take;
        logic [IDX_MAX_W-1:0]  idx;
        logic [STAMP_W-1:0]    stamp;
        logic [PAGE_MAX_W-1:0] owner;
    } t_cell_wr;

endpackage

`default_nettype wire

// File: hdl/page_translate_lru_unit.sv
// Top level of the demand-paging address translator with LRU frame replacement.
//
// The input channel takes one 12-bit virtual address per word (i_valid, o_stall).
// The output channel returns one word per input: the physical address, a page
// fault flag and the saturating fault total (o_valid, i_stall).
// The page table sits in a memory of PAGE_COUNT entries with one read and one
// write port. Frames 1 to FRAME_COUNT-1 live in a row of cells; on a miss a
// search word walks the row, one cell per cycle, and picks the lowest free
// frame or else the least recently used one.
// With a power-of-two PAGE_COUNT the page number is cut from the address bits;
// a hit then passes the states read, look, update and output, and a miss passes
// read, look, scan, fill and output, held in scan for the walk through the cell
// row. Otherwise the page number is reduced by a reciprocal multiply and a
// subtract in the states mod and rem before the read.
// After reset the block clears the page table, one entry per cycle, with o_stall
// high. A result waits in the output register while i_stall is high; the next
// word is still taken and worked on, and only its final write to the output
// register waits.
`default_nettype none

module page_translate_lru_unit #(
    parameter int PAGE_COUNT  = 32,
    parameter int FRAME_COUNT = 8,
    parameter int OFFSET_BITS = 7
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [ptlru_pkg::VA_W-1:0]   i_virtual_address,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [ptlru_pkg::PHYS_W-1:0]      o_physical_address,
    output logic                              o_page_fault,
    output logic [ptlru_pkg::FAULT_W-1:0]     o_fault_total
);
    import ptlru_pkg::*;

    localparam int PAGE_W    = $clog2(PAGE_COUNT);
    localparam int FRAME_W   = $clog2(FRAME_COUNT);
    localparam int OFF_EFF   = (OFFSET_BITS > VA_W) ? VA_W : OFFSET_BITS;
    localparam int RAW_W     = (VA_W - OFF_EFF > 0) ? (VA_W - OFF_EFF) : 1;
    localparam int MOD_W     = RAW_W + PAGE_W + 1;
    localparam int RECIP_SH  = RAW_W + PAGE_W;
    localparam int PROD_W    = RAW_W + RECIP_SH;
    localparam bit PAGE_POW2 = ((PAGE_COUNT & (PAGE_COUNT - 1)) == 0);

    localparam logic [RECIP_SH-1:0] RECIP = RECIP_SH'(
        ((64'd1 << RECIP_SH) + 64'(PAGE_COUNT) - 64'd1) / 64'(PAGE_COUNT));
    localparam logic [31:0]         OFF_MASK32 = (32'd1 << OFFSET_BITS) - 32'd1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_REM,
        S_READ,
        S_LOOK,
        S_UPD,
        S_SCAN,
        S_FILL,
        S_OUT
    } t_state;

    t_state               r_state;
    logic [PAGE_W-1:0]    r_clr;
    logic [VA_W-1:0]      r_va;
    logic [PAGE_W-1:0]    r_page;
    logic [RAW_W-1:0]     r_raw;
    logic [RAW_W-1:0]     r_quo;
    logic [FRAME_W-1:0]   r_frame;
    logic                 r_fault;
    logic [STAMP_W-1:0]   r_clock;
    logic [FAULT_W-1:0]   r_fcnt;
    logic                 r_out_valid;
    logic [PHYS_W-1:0]    r_out_pa;
    logic                 r_out_fault;
    logic [FAULT_W-1:0]   r_out_total;

    logic [FRAME_W:0]     r_mem [PAGE_COUNT];
    logic [FRAME_W:0]     r_rd;
    logic                 w_we;
    logic [PAGE_W-1:0]    w_waddr;
    logic [FRAME_W:0]     w_wdata;

    t_cand                w_cand [FRAME_COUNT];
    t_cand                w_final;
    t_cell_wr             w_wr;

    logic [31:0]          w_in_raw32;
    logic [31:0]          w_offset32;
    logic [31:0]          w_phys32;
    logic [PROD_W-1:0]    w_prod;
    logic [MOD_W-1:0]     w_rem;

    assign w_in_raw32 = 32'(i_virtual_address) >> OFFSET_BITS;
    assign w_offset32 = 32'(r_va) & OFF_MASK32;
    assign w_phys32   = (32'(r_frame) << OFFSET_BITS) + w_offset32;
    assign w_final    = w_cand[FRAME_COUNT-1];
    assign w_prod     = PROD_W'(r_raw) * PROD_W'(RECIP);
    assign w_rem      = MOD_W'(r_raw) - MOD_W'(r_quo) * MOD_W'(PAGE_COUNT);

    always_comb begin
        w_cand[0]       = '0;
        w_cand[0].valid = (r_state == S_LOOK) && !r_rd[FRAME_W];
    end

    for (genvar g = 1; g < FRAME_COUNT; g++) begin : g_cell
        ptlru_cell #(
            .FRAME_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cand  (w_cand[g-1]),
            .i_wr    (w_wr),
            .o_cand  (w_cand[g])
        );
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_page;
        w_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
            end
            S_SCAN: begin
                w_we    = w_final.valid && !w_final.free;
                w_waddr = w_final.owner[PAGE_W-1:0];
            end
            S_FILL: begin
                w_we    = 1'b1;
                w_wdata = {1'b1, r_frame};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_wr       = '0;
        w_wr.idx   = IDX_MAX_W'(r_frame);
        w_wr.stamp = r_clock;
        w_wr.owner = PAGE_MAX_W'(r_page);
        unique case (r_state)
            S_UPD: begin
                w_wr.en = 1'b1;
            end
            S_FILL: begin
                w_wr.en   = 1'b1;
                w_wr.take = 1'b1;
            end
            default: begin
                w_wr.en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[r_page];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_clock     <= '0;
            r_fcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr == PAGE_W'(PAGE_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_va <= i_virtual_address;
                        if (PAGE_POW2) begin
                            r_page  <= w_in_raw32[PAGE_W-1:0];
                            r_state <= S_READ;
                        end else begin
                            r_raw   <= w_in_raw32[RAW_W-1:0];
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    r_quo   <= w_prod[PROD_W-1:RECIP_SH];
                    r_state <= S_REM;
                end
                S_REM: begin
                    r_page  <= w_rem[PAGE_W-1:0];
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_LOOK;
                end
                S_LOOK: begin
                    r_clock <= r_clock + 32'd1;
                    r_fault <= !r_rd[FRAME_W];
                    r_frame <= r_rd[FRAME_W-1:0];
                    r_state <= r_rd[FRAME_W] ? S_UPD : S_SCAN;
                end
                S_UPD: begin
                    r_state <= S_OUT;
                end
                S_SCAN: begin
                    if (w_final.valid) begin
                        r_frame <= w_final.idx[FRAME_W-1:0];
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    if (r_fcnt != FAULT_MAX) begin
                        r_fcnt <= r_fcnt + 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_pa    <= w_phys32[PHYS_W-1:0];
                        r_out_fault <= r_fault;
                        r_out_total <= r_fcnt;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    assign o_stall            = (r_state != S_IDLE);
    assign o_valid            = r_out_valid;
    assign o_physical_address = r_out_pa;
    assign o_page_fault       = r_out_fault;
    assign o_fault_total      = r_out_total;

endmodule

`default_nettype wire

// File: hdl/ptlru_cell.sv
// One frame cell: holds a frame's free flag, last-use stamp and owner page, and passes the search word on.
`default_nettype none

module ptlru_cell #(
    parameter int FRAME_IDX = 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ptlru_pkg::t_cand    i_cand,
    input  wire ptlru_pkg::t_cell_wr i_wr,
    output ptlru_pkg::t_cand         o_cand
);
    import ptlru_pkg::*;

    localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(FRAME_IDX);

    logic                  r_free;
    logic [STAMP_W-1:0]    r_stamp;
    logic [PAGE_MAX_W-1:0] r_owner;
    t_cand                 r_cand;
    t_cand                 n_cand;
    logic                  w_sel;

    assign w_sel = i_wr.en && (i_wr.idx == MY_IDX);

    // A free frame wins over any used one; among used frames the oldest stamp wins,
    // and an equal stamp keeps the lower index already in the word.
    always_comb begin
        n_cand = i_cand;
        if (i_cand.valid && !i_cand.free) begin
            if (r_free) begin
                n_cand.have  = 1'b1;
                n_cand.free  = 1'b1;
                n_cand.idx   = MY_IDX;
                n_cand.stamp = r_stamp;
                n_cand.owner = r_owner;
            end else if (!i_cand.have || (r_stamp < i_cand.stamp)) begin
                n_cand.have  = 1'b1;
                n_cand.free  = 1'b0;
                n_cand.idx   = MY_IDX;
                n_cand.stamp = r_stamp;
                n_cand.owner = r_owner;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free       <= 1'b1;
            r_stamp      <= '0;
            r_cand.valid <= 1'b0;
        end else begin
            r_cand <= n_cand;
            if (w_sel) begin
                r_stamp <= i_wr.stamp;
                if (i_wr.take) begin
                    r_free <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel && i_wr.take) begin
            r_owner <= i_wr.owner;
        end
    end

    assign o_cand = r_cand;

endmodule

`default_nettype wire

// File: hdl/ptlru_checker.sv
// Port-level checks for the page translation unit and the bind that attaches them.
`default_nettype none

module ptlru_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          o_stall,
    input wire logic                          o_valid,
    input wire logic                          i_stall,
    input wire logic [ptlru_pkg::PHYS_W-1:0]  o_physical_address,
    input wire logic                          o_page_fault,
    input wire logic [ptlru_pkg::FAULT_W-1:0] o_fault_total
);

    // The block holds off new words while the page table is being cleared.
    a_clear_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("input not stalled after reset");

    // A taken word keeps the input side stalled while it is translated.
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input open in the cycle after a word was taken");

    // A faulting result always carries a nonzero fault total.
    a_fault_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_page_fault) |-> (o_fault_total != '0))
        else $error("fault reported with a zero fault total");

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_physical_address)
            && $stable(o_page_fault) && $stable(o_fault_total)))
        else $error("stalled result changed");

endmodule

bind page_translate_lru_unit ptlru_checker u_ptlru_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_physical_address (o_physical_address),
    .o_page_fault       (o_page_fault),
    .o_fault_total      (o_fault_total)
);

`default_nettype wire
